// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

    // Decoder phase within the input stream.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    // Progress through the four bytes that follow a \u escape.
    typedef enum logic [1:0] {
        HM_SKIP   = 2'd0,
        HM_DIGITS = 2'd1,
        HM_DONE   = 2'd2
    } hex_mode_t;

    // Result kinds.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_CLOSED   = 2'd1;
    localparam logic [1:0] KIND_NO_QUOTE = 2'd2;
    localparam logic [1:0] KIND_PREMAT   = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CC_BS    = 8'h08;
    localparam logic [7:0] CC_FF    = 8'h0C;
    localparam logic [7:0] CC_LF    = 8'h0A;
    localparam logic [7:0] CC_CR    = 8'h0D;
    localparam logic [7:0] CC_TAB   = 8'h09;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } result_t;

    // Space, tab, LF, VT, FF or CR.
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Hex digit value in the low four bits, bit 4 set when b is no hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = {1'b0, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            d = {1'b0, b[3:0] + 4'd9};
        end
        else begin
            d = 5'h10;
        end
        return d;
    endfunction

endpackage

// ===== hdl/json_string_unescaper.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid, in_stall, in_byte, end_of_input | in_stall driven here
// output  | out_valid, out_stall, out_byte, kind, last | out_stall driven by sink
//
// One byte is decoded per cycle while in_stall is low: every transfer updates the
// decoder state and, when it yields a result, loads it in the same clock into the
// output register, or into the skid register while out_stall holds the output.
// A two-entry output buffer (output register plus skid register) keeps input
// transfers flowing while a result waits; in_stall rises only when both are full.
// Reset (rst_n, asynchronous, active low) idles the decoder and empties the buffer.
module json_string_unescaper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);
    import jsu_pkg::*;

    phase_t     phase_reg, phase_next;
    hex_mode_t  hex_mode_reg, hex_mode_next;
    logic [1:0] hex_left_reg, hex_left_next;
    logic [7:0] hex_value_reg, hex_value_next;

    result_t    out_reg, skid_reg, res;
    logic       out_valid_reg, skid_valid_reg;
    logic       res_valid;
    logic       accept;
    logic       out_free;
    logic [4:0] digit;
    hex_mode_t  hm_upd;
    logic [7:0] hv_upd;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign digit    = hex_digit(in_byte);

    // Hex digit step within a \u escape.
    always_comb
    begin
        hm_upd = hex_mode_reg;
        hv_upd = hex_value_reg;
        if (hex_mode_reg == HM_SKIP && is_space(in_byte)) begin
            hm_upd = HM_SKIP;
        end
        else if (hex_mode_reg != HM_DONE && !digit[4]) begin
            hm_upd = HM_DIGITS;
            hv_upd = {hex_value_reg[3:0], digit[3:0]};
        end
        else begin
            hm_upd = HM_DONE;
        end
    end

    // Result of the current byte.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '{data: 8'h00, kind: KIND_DATA, last: 1'b0};
        if (end_of_input) begin
            res_valid = 1'b1;
            res.kind  = (phase_reg == PH_IDLE) ? KIND_NO_QUOTE : KIND_PREMAT;
            res.last  = 1'b1;
        end
        else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!is_space(in_byte) && in_byte != CH_QUOTE) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_NO_QUOTE;
                        res.last  = 1'b1;
                    end
                end
                PH_STR:
                begin
                    if (in_byte == CH_QUOTE) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_CLOSED;
                        res.last  = 1'b1;
                    end
                    else if (in_byte != CH_BSL) begin
                        res_valid = 1'b1;
                        res.data  = in_byte;
                    end
                end
                PH_ESC:
                begin
                    res_valid = (in_byte != CH_U);
                    case (in_byte)
                        CH_B:    res.data = CC_BS;
                        CH_F:    res.data = CC_FF;
                        CH_N:    res.data = CC_LF;
                        CH_R:    res.data = CC_CR;
                        CH_T:    res.data = CC_TAB;
                        default: res.data = in_byte;
                    endcase
                end
                PH_HEX:
                begin
                    if (hex_left_reg == 2'd0) begin
                        res_valid = 1'b1;
                        res.data  = hv_upd;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Next decoder state.
    always_comb
    begin
        phase_next     = phase_reg;
        hex_mode_next  = hex_mode_reg;
        hex_left_next  = hex_left_reg;
        hex_value_next = hex_value_reg;
        if (end_of_input) begin
            phase_next     = PH_IDLE;
            hex_mode_next  = HM_SKIP;
            hex_left_next  = 2'd0;
            hex_value_next = 8'h00;
        end
        else begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == CH_QUOTE) begin
                        phase_next = PH_STR;
                    end
                end
                PH_STR:
                begin
                    if (in_byte == CH_QUOTE) begin
                        phase_next = PH_IDLE;
                    end
                    else if (in_byte == CH_BSL) begin
                        phase_next = PH_ESC;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_STR;
                    if (in_byte == CH_U) begin
                        phase_next     = PH_HEX;
                        hex_left_next  = 2'd3;
                        hex_mode_next  = HM_SKIP;
                        hex_value_next = 8'h00;
                    end
                end
                PH_HEX:
                begin
                    if (hex_left_reg == 2'd0) begin
                        phase_next     = PH_STR;
                        hex_mode_next  = HM_SKIP;
                        hex_value_next = 8'h00;
                    end
                    else begin
                        hex_mode_next  = hm_upd;
                        hex_value_next = hv_upd;
                        hex_left_next  = hex_left_reg - 2'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Decoder state registers, updated on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            hex_mode_reg  <= HM_SKIP;
            hex_left_reg  <= 2'd0;
            hex_value_reg <= 8'h00;
        end
        else if (accept) begin
            phase_reg     <= phase_next;
            hex_mode_reg  <= hex_mode_next;
            hex_left_reg  <= hex_left_next;
            hex_value_reg <= hex_value_next;
        end
    end

    // Output register and skid register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                out_valid_reg <= accept && res_valid;
            end
        end
        else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end
            else if (accept && res_valid) begin
                out_reg <= res;
            end
        end
        else if (accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign kind      = out_reg.kind;
    assign last      = out_reg.last;

    // A result waits in the skid register only behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // A result that ends the string sends the decoder back to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && res.last) |=> (phase_reg == PH_IDLE))
        else $error("decoder not idle after a final result");

    // The digit counter is only live inside a \u escape.
    a_hex_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEX) |-> (hex_left_reg == 2'd0))
        else $error("digit counter nonzero outside a \\u escape");

    // The last flag marks exactly the non-data results.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last == (kind != KIND_DATA)))
        else $error("last flag disagrees with result kind");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // One raw byte of the input stream, or the end-of-stream marker.
    typedef struct {
        logic [7:0] b;
        logic       eoi;
    } raw_item_t;

    // How a generated string is finished.
    localparam int END_CLOSE = 0;
    localparam int END_EOI   = 1;
    localparam int END_CUT   = 2;

    // Receiver stall patterns.
    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [7:0] SPACE_CHARS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    localparam logic [7:0] SIMPLE_ESC [5]  = '{CH_B, CH_F, CH_N, CH_R, CH_T};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    raw_item_t bytes_to_send [$];
    result_t   expected_decodes [$];
    int        counted_items = 0;
    int        bytes_taken = 0;
    int        errors = 0;
    int        results_by_kind [4] = '{0, 0, 0, 0};
    int        in_stall_cycles = 0;

    // Decoder state mirrored by the predictor.
    phase_t     dec_phase = PH_IDLE;
    logic [1:0] dec_left = 2'd0;
    hex_mode_t  dec_mode = HM_SKIP;
    logic [7:0] dec_value = 8'h00;

    json_string_unescaper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .kind         (kind),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the decoder by one input transfer and give the result it yields, if any.
    function automatic void unescape_step(input logic [7:0] b, input logic eoi,
                                          output bit produced, output result_t res);
        logic       ws;
        logic [4:0] nib;
        produced = 1'b0;
        res = '0;
        ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        if (b >= 8'h30 && b <= 8'h39) nib = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) nib = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) nib = 5'(b - 8'h37);
        else nib = 5'h10;

        if (eoi)
        begin
            produced = 1'b1;
            res.kind = (dec_phase == PH_IDLE) ? KIND_NO_QUOTE : KIND_PREMAT;
        end
        else
        begin
            case (dec_phase)
                PH_IDLE:
                begin
                    if (b == CH_QUOTE) dec_phase = PH_STR;
                    else if (!ws)
                    begin
                        produced = 1'b1;
                        res.kind = KIND_NO_QUOTE;
                    end
                end
                PH_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        produced = 1'b1;
                        res.kind = KIND_CLOSED;
                    end
                    else if (b == CH_BSL) dec_phase = PH_ESC;
                    else
                    begin
                        produced = 1'b1;
                        res.data = b;
                    end
                end
                PH_ESC:
                begin
                    dec_phase = PH_STR;
                    produced = 1'b1;
                    case (b)
                        CH_B: res.data = CC_BS;
                        CH_F: res.data = CC_FF;
                        CH_N: res.data = CC_LF;
                        CH_R: res.data = CC_CR;
                        CH_T: res.data = CC_TAB;
                        CH_U:
                        begin
                            produced = 1'b0;
                            dec_phase = PH_HEX;
                            dec_left = 2'd3;
                            dec_mode = HM_SKIP;
                            dec_value = 8'h00;
                        end
                        default: res.data = b;
                    endcase
                end
                default:
                begin
                    // Four bytes follow \u: skip leading blanks, take digits, ignore the rest.
                    if (dec_mode == HM_SKIP && ws)
                    begin
                    end
                    else if (dec_mode != HM_DONE && !nib[4])
                    begin
                        dec_mode = HM_DIGITS;
                        dec_value = {dec_value[3:0], nib[3:0]};
                    end
                    else dec_mode = HM_DONE;
                    if (dec_left == 2'd0)
                    begin
                        produced = 1'b1;
                        res.data = dec_value;
                        dec_phase = PH_STR;
                        dec_mode = HM_SKIP;
                        dec_value = 8'h00;
                    end
                    else dec_left = dec_left - 2'd1;
                end
            endcase
        end

        // Any closing or failing result returns the decoder to idle.
        if (produced && res.kind != KIND_DATA)
        begin
            res.last = 1'b1;
            dec_phase = PH_IDLE;
            dec_left = 2'd0;
            dec_mode = HM_SKIP;
            dec_value = 8'h00;
        end
    endfunction

    function automatic void queue_item(input logic [7:0] b, input logic eoi);
        raw_item_t it;
        it.b = b;
        it.eoi = eoi;
        bytes_to_send.push_back(it);
        counted_items++;
    endfunction

    function automatic logic [7:0] rand_space();
        return SPACE_CHARS[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + (v - 10));
    endfunction

    // Queue one quoted string with random content, finished as the ending asks.
    task automatic add_string(input int ending);
        int         units;
        int         cut_at;
        int         cut_k;
        int         pick;
        bit         leading;
        logic [7:0] c;
        repeat ($urandom_range(0, 2)) queue_item(rand_space(), 1'b0);
        queue_item(CH_QUOTE, 1'b0);
        units = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 10);
        if (ending == END_CUT && units == 0) units = 1;
        cut_at = (ending == END_CUT) ? $urandom_range(0, units - 1) : -1;
        for (int i = 0; i < units; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                if (i == cut_at)
                begin
                    queue_item(8'($urandom), 1'b1);
                    return;
                end
                do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSL);
                queue_item(c, 1'b0);
            end
            else if (pick < 75)
            begin
                queue_item(CH_BSL, 1'b0);
                if (i == cut_at)
                begin
                    queue_item(8'($urandom), 1'b1);
                    return;
                end
                if (pick < 65) c = SIMPLE_ESC[$urandom_range(0, 4)];
                else
                    do c = 8'($urandom);
                    while (c == CH_B || c == CH_F || c == CH_N || c == CH_R || c == CH_T
                           || c == CH_U);
                queue_item(c, 1'b0);
            end
            else
            begin
                queue_item(CH_BSL, 1'b0);
                queue_item(CH_U, 1'b0);
                cut_k = (i == cut_at) ? $urandom_range(0, 3) : 4;
                leading = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    if (k == cut_k)
                    begin
                        queue_item(8'($urandom), 1'b1);
                        return;
                    end
                    pick = $urandom_range(0, 9);
                    if (leading && pick < 3) c = rand_space();
                    else
                    begin
                        leading = 1'b0;
                        c = (pick < 8) ? rand_hex_char() : 8'($urandom);
                    end
                    queue_item(c, 1'b0);
                end
            end
        end
        if (ending == END_CLOSE) queue_item(CH_QUOTE, 1'b0);
        else queue_item(8'($urandom), 1'b1);
    endtask

    // Sender: offers queued bytes in bursts with random gaps, holding while stalled.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : sender
        raw_item_t nxt;
        bit        produced;
        result_t   res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= 8'h00;
            end_of_input <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                unescape_step(in_byte, end_of_input, produced, res);
                if (produced) expected_decodes.push_back(res);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (bytes_to_send.size() > 0)
                begin
                    nxt = bytes_to_send.pop_front();
                    in_byte <= nxt.b;
                    end_of_input <= nxt.eoi;
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls on a changing pattern, with one long hold-off mid-run.
    int  stall_mode = STALL_NONE;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        logic stall_next;
        if (!rst_n) out_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
                mode_left = $urandom_range(20, 200);
            end
            else mode_left--;
            if (!hold_done && bytes_taken >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:  stall_next = 1'b0;
                    STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                    default:     stall_next = !out_stall;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // Monitor: every output transfer must match the oldest expected result.
    always @(posedge clk)
    begin : monitor
        result_t exp_res;
        if (rst_n)
        begin
            if (in_valid && in_stall) in_stall_cycles++;
            if (out_valid && !out_stall)
            begin
                results_by_kind[kind]++;
                if (expected_decodes.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h kind %0d last %0b",
                           out_byte, kind, last);
                    errors++;
                end
                else
                begin
                    exp_res = expected_decodes.pop_front();
                    if (out_byte !== exp_res.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", exp_res.data, out_byte);
                        errors++;
                    end
                    if (kind !== exp_res.kind)
                    begin
                        $error("kind: expected %0d, got %0d", exp_res.kind, kind);
                        errors++;
                    end
                    if (last !== exp_res.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_res.last, last);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int pick;

        // Directed: end while idle, bad first byte, the b/f/n/r/t escapes, a \u, a premature end.
        queue_item(8'hA5, 1'b1);
        queue_item(8'h0D, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h20, 1'b0);
        queue_item(8'h09, 1'b0);
        queue_item(CH_QUOTE, 1'b0);
        queue_item(8'h00, 1'b0);
        foreach (SIMPLE_ESC[i])
        begin
            queue_item(CH_BSL, 1'b0);
            queue_item(SIMPLE_ESC[i], 1'b0);
        end
        queue_item(CH_BSL, 1'b0);
        queue_item(CH_U, 1'b0);
        queue_item(8'h20, 1'b0);
        queue_item(8'h31, 1'b0);
        queue_item(8'h41, 1'b0);
        queue_item(8'h67, 1'b0);
        queue_item(CH_QUOTE, 1'b0);
        queue_item(CH_QUOTE, 1'b0);
        queue_item(CH_BSL, 1'b0);
        queue_item(8'h5A, 1'b1);

        // Random: mostly well-formed strings, some noise and broken strings.
        while (counted_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72) add_string(END_CLOSE);
            else if (pick < 76) add_string(END_EOI);
            else if (pick < 86) add_string(END_CUT);
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 6))
                    queue_item(8'($urandom), ($urandom_range(0, 7) == 0));
                queue_item(8'($urandom), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(0, 2)) queue_item(rand_space(), 1'b0);
                queue_item(8'($urandom), 1'b1);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (bytes_to_send.size() != 0 || in_valid) @(posedge clk);
        while (expected_decodes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d bytes sent, results: %0d data, %0d closed, %0d no quote, %0d %s",
                 bytes_taken, results_by_kind[KIND_DATA], results_by_kind[KIND_CLOSED],
                 results_by_kind[KIND_NO_QUOTE], results_by_kind[KIND_PREMAT], "premature");
        $display("summary: input held back by the block for %0d cycles", in_stall_cycles);
        if (errors == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
